// File: sv/tpqd_pkg.sv
`default_nettype none
package tpqd_pkg;

  localparam int MAX_AXES     = 4;
  localparam int AXES_DEFAULT = 4;

  localparam int TIME_W = 48;
  localparam int POS_W  = 32;
  localparam int STEP_W = 30;

  localparam logic [STEP_W-1:0] STEP_RESET = 30'd10000;

  localparam int S_TDATA_W = TIME_W + MAX_AXES * POS_W;
  localparam int M_TDATA_W = TIME_W + 2 * MAX_AXES * POS_W;

  localparam int DA_W  = TIME_W + 1;
  localparam int SQ_W  = DA_W + TIME_W;
  localparam int DEN_W = SQ_W + DA_W;
  localparam int DP_W  = POS_W + 1;

  localparam int VEL_SCALE_W = 30;
  localparam int ACC_SCALE_W = 61;
  localparam logic [VEL_SCALE_W-1:0] VEL_SCALE = 30'd1000000000;
  localparam logic [ACC_SCALE_W-1:0] ACC_SCALE = 61'd2000000000000000000;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_P1_GO,
    ST_P1_WAIT,
    ST_P2_GO,
    ST_P2_WAIT,
    ST_P3_GO,
    ST_P3_WAIT,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_DONE
  } st_e;

  typedef struct packed {
    logic win_we;
    logic win_shift;
    logic p1_go;
    logic p2_go;
    logic p3_go;
    logic div_go;
  } lane_ctrl_t;

endpackage
`default_nettype wire

// File: sv/three_point_quadratic_derivatives.sv
// Three-point quadratic derivative estimator.
// Input stream s_axis: one word per trajectory point, tdata holds the raw time and the
// four axis positions, tlast marks the final point of a trajectory and clears the window.
// Output stream m_axis: one word per centre point, carrying the corrected centre time and
// the saturated velocity and acceleration of every axis.
// The first two points of a trajectory fill the window and are taken with no result.
// Every later point starts a computation of span products, the scaled second products,
// the velocity scaling and rounding division, done by the bit-serial multipliers and
// dividers of the shared datapath and of each axis lane. s_axis_tready is low during
// that time.
// The result goes to an output register; the next point is accepted as soon as the
// result is loaded, even while m_axis_tready is low. A stall longer than one computation
// holds the block in its final step until the register is free.
// cfg_we_i writes min_step_ns; users must do so while the block is idle (not enforced).
// Reset empties the window, clears the output valid and sets min_step_ns to 10000.
`default_nettype none
module three_point_quadratic_derivatives #(
  parameter int AXES = tpqd_pkg::AXES_DEFAULT
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [tpqd_pkg::STEP_W-1:0]        cfg_wdata_i,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // point_time, pos_axis0, pos_axis1, pos_axis2, pos_axis3
  input  logic [tpqd_pkg::S_TDATA_W-1:0]     s_axis_tdata,
  input  logic                               s_axis_tlast,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // center_time, vel_axis0..vel_axis3, acc_axis0..acc_axis3
  output logic [tpqd_pkg::M_TDATA_W-1:0]     m_axis_tdata
);
  import tpqd_pkg::*;

  st_e state_q, state_d;

  logic [STEP_W-1:0] step_q;
  logic [1:0]        fill_q, fill_d;
  logic [TIME_W-1:0] older_q, middle_q;
  logic [TIME_W-1:0] d1_q, d2_q, ct_q;
  logic              zero_q;
  logic              accept;
  logic              out_load;
  logic              m_valid_q, m_valid_d;
  logic [M_TDATA_W-1:0] m_data_q, m_data_d;

  logic [TIME_W-1:0] raw, t_corr;
  logic [TIME_W:0]   lim, tmax;

  lane_ctrl_t ctrl;

  assign raw    = s_axis_tdata[TIME_W-1:0];
  assign accept = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE);

  assign lim  = {1'b0, middle_q} + (TIME_W + 1)'(step_q);
  assign tmax = ({1'b0, raw} > lim) ? {1'b0, raw} : lim;

  always_comb begin
    if (fill_q == 2'd0) begin
      t_corr = raw;
    end else if (tmax[TIME_W]) begin
      t_corr = '1;
    end else begin
      t_corr = tmax[TIME_W-1:0];
    end
  end

  always_comb begin
    if (s_axis_tlast) begin
      fill_d = 2'd0;
    end else if (fill_q != 2'd0) begin
      fill_d = 2'd2;
    end else begin
      fill_d = 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= STEP_RESET;
    end else if (cfg_we_i) begin
      step_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q    <= 2'd0;
      state_q   <= ST_IDLE;
      m_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        fill_q <= fill_d;
      end
      state_q   <= state_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      d1_q   <= middle_q - older_q;
      d2_q   <= t_corr - middle_q;
      zero_q <= (middle_q == older_q) || (t_corr == middle_q);
      ct_q   <= middle_q;
      if (fill_q != 2'd0) begin
        older_q <= middle_q;
      end
      middle_q <= t_corr;
    end
    if (out_load) begin
      m_data_q <= m_data_d;
    end
  end

  logic signed [SQ_W-1:0]  d1sq, d2sq, d1d2;
  logic signed [DEN_W-1:0] den;
  logic [3:0]              cbusy;
  logic [MAX_AXES-1:0]     lbusy;
  logic                    any_busy;

  assign ctrl.win_we    = accept;
  assign ctrl.win_shift = (fill_q != 2'd0);
  assign ctrl.p1_go     = (state_q == ST_P1_GO);
  assign ctrl.p2_go     = (state_q == ST_P2_GO);
  assign ctrl.p3_go     = (state_q == ST_P3_GO);
  assign ctrl.div_go    = (state_q == ST_DIV_GO);

  tpqd_smul #(.WA(DA_W), .NB(TIME_W), .B_SIGNED(1'b0)) u_d1sq (
    .clk_i, .rst_ni, .start_i(ctrl.p1_go), .a_i($signed({1'b0, d1_q})),
    .b_i(d1_q), .busy_o(cbusy[0]), .p_o(d1sq)
  );

  tpqd_smul #(.WA(DA_W), .NB(TIME_W), .B_SIGNED(1'b0)) u_d2sq (
    .clk_i, .rst_ni, .start_i(ctrl.p1_go), .a_i($signed({1'b0, d2_q})),
    .b_i(d2_q), .busy_o(cbusy[1]), .p_o(d2sq)
  );

  tpqd_smul #(.WA(DA_W), .NB(TIME_W), .B_SIGNED(1'b0)) u_d1d2 (
    .clk_i, .rst_ni, .start_i(ctrl.p1_go), .a_i($signed({1'b0, d1_q})),
    .b_i(d2_q), .busy_o(cbusy[2]), .p_o(d1d2)
  );

  tpqd_smul #(.WA(SQ_W), .NB(DA_W), .B_SIGNED(1'b0)) u_den (
    .clk_i, .rst_ni, .start_i(ctrl.p2_go), .a_i(d1d2),
    .b_i({1'b0, d1_q} + {1'b0, d2_q}), .busy_o(cbusy[3]), .p_o(den)
  );

  logic [POS_W-1:0] vel_w [MAX_AXES];
  logic [POS_W-1:0] acc_w [MAX_AXES];

  for (genvar g = 0; g < MAX_AXES; g++) begin : g_lane
    if (g < AXES) begin : g_on
      tpqd_lane u_lane (
        .clk_i, .rst_ni, .ctrl_i(ctrl),
        .pos_i(s_axis_tdata[TIME_W + g * POS_W +: POS_W]),
        .d1_i(d1_q), .d2_i(d2_q), .d1sq_i(d1sq), .d2sq_i(d2sq),
        .den_i(den[DEN_W-2:0]), .busy_o(lbusy[g]),
        .vel_o(vel_w[g]), .acc_o(acc_w[g])
      );
    end else begin : g_off
      assign lbusy[g] = 1'b0;
      assign vel_w[g] = '0;
      assign acc_w[g] = '0;
    end
  end

  assign any_busy = (|cbusy) | (|lbusy);

  always_comb begin
    m_data_d = '0;
    m_data_d[TIME_W-1:0] = ct_q;
    for (int i = 0; i < MAX_AXES; i++) begin
      m_data_d[TIME_W + i * POS_W +: POS_W] = zero_q ? '0 : vel_w[i];
      m_data_d[TIME_W + (MAX_AXES + i) * POS_W +: POS_W] = zero_q ? '0 : acc_w[i];
    end
  end

  always_comb begin
    state_d   = state_q;
    out_load  = 1'b0;
    m_valid_d = m_valid_q;
    if (m_axis_tready) begin
      m_valid_d = 1'b0;
    end
    case (state_q)
      ST_IDLE: begin
        if (accept && (fill_q == 2'd2)) begin
          state_d = ST_P1_GO;
        end
      end
      ST_P1_GO:   state_d = ST_P1_WAIT;
      ST_P1_WAIT: if (!any_busy) state_d = ST_P2_GO;
      ST_P2_GO:   state_d = ST_P2_WAIT;
      ST_P2_WAIT: if (!any_busy) state_d = ST_P3_GO;
      ST_P3_GO:   state_d = ST_P3_WAIT;
      ST_P3_WAIT: if (!any_busy) state_d = ST_DIV_GO;
      ST_DIV_GO:  state_d = ST_DIV_WAIT;
      ST_DIV_WAIT: if (!any_busy) state_d = ST_DONE;
      ST_DONE: begin
        if (!m_valid_q || m_axis_tready) begin
          out_load  = 1'b1;
          m_valid_d = 1'b1;
          state_d   = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

endmodule
`default_nettype wire

// File: sv/tpqd_smul.sv
`default_nettype none
module tpqd_smul #(
  parameter int WA       = 8,
  parameter int NB       = 8,
  parameter bit B_SIGNED = 1'b0
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic signed [WA-1:0]     a_i,
  input  logic        [NB-1:0]     b_i,
  output logic                     busy_o,
  output logic signed [WA+NB-1:0]  p_o
);

  localparam int WP = WA + NB;
  localparam int CW = $clog2(NB + 1);

  logic [CW-1:0]        cnt_q, cnt_d;
  logic signed [WP-1:0] acc_q, acc_d;
  logic signed [WP-1:0] ash_q, ash_d;
  logic [NB-1:0]        b_q, b_d;

  always_comb begin
    cnt_d = cnt_q;
    acc_d = acc_q;
    ash_d = ash_q;
    b_d   = b_q;
    if (start_i) begin
      acc_d = '0;
      ash_d = {{NB{a_i[WA-1]}}, a_i};
      b_d   = b_i;
      cnt_d = CW'(NB);
    end else if (cnt_q != '0) begin
      if (b_q[0]) begin
        if (B_SIGNED && (cnt_q == CW'(1))) begin
          acc_d = acc_q - ash_q;
        end else begin
          acc_d = acc_q + ash_q;
        end
      end
      ash_d = ash_q << 1;
      b_d   = b_q >> 1;
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    ash_q <= ash_d;
    b_q   <= b_d;
  end

  assign busy_o = (cnt_q != '0);
  assign p_o    = acc_q;

endmodule
`default_nettype wire

// File: sv/tpqd_rdiv.sv
`default_nettype none
module tpqd_rdiv #(
  parameter int WN = 16,
  parameter int WD = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic signed [WN-1:0] num_i,
  input  logic [WD-1:0]        den_i,
  output logic                 busy_o,
  output logic [31:0]          quo_o
);

  localparam int QB     = 32;
  localparam int STEPS  = QB + 1;
  localparam int WR     = ((WN + 2) > (WD + QB + 1)) ? (WN + 2) : (WD + QB + 1);
  localparam int CW     = $clog2(STEPS + 1);

  logic [CW-1:0]  cnt_q, cnt_d;
  logic [WR-1:0]  rem_q, rem_d;
  logic [WR-1:0]  dv_q, dv_d;
  logic [QB-1:0]  q_q, q_d;
  logic           sat_q, sat_d;
  logic           neg_q, neg_d;
  logic [WN-1:0]  mag;
  logic           ge;
  logic [QB-1:0]  lim;
  logic [QB-1:0]  m;

  assign mag = num_i[WN-1] ? WN'(-num_i) : WN'(num_i);
  assign ge  = (rem_q >= dv_q);

  always_comb begin
    cnt_d = cnt_q;
    rem_d = rem_q;
    dv_d  = dv_q;
    q_d   = q_q;
    sat_d = sat_q;
    neg_d = neg_q;
    if (start_i) begin
      neg_d = num_i[WN-1];
      rem_d = WR'({mag, 1'b0}) + WR'(den_i);
      dv_d  = WR'({den_i, {(QB + 1){1'b0}}});
      q_d   = '0;
      sat_d = 1'b0;
      cnt_d = CW'(STEPS);
    end else if (cnt_q != '0) begin
      if (cnt_q == CW'(STEPS)) begin
        sat_d = ge;
      end else begin
        if (ge) begin
          rem_d = rem_q - dv_q;
        end
        q_d = {q_q[QB-2:0], ge};
      end
      dv_d  = dv_q >> 1;
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dv_q  <= dv_d;
    q_q   <= q_d;
    sat_q <= sat_d;
    neg_q <= neg_d;
  end

  assign lim    = neg_q ? 32'h8000_0000 : 32'h7FFF_FFFF;
  assign m      = (sat_q || (q_q > lim)) ? lim : q_q;
  assign quo_o  = neg_q ? (32'd0 - m) : m;
  assign busy_o = (cnt_q != '0);

endmodule
`default_nettype wire

// File: sv/tpqd_lane.sv
`default_nettype none
module tpqd_lane (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  tpqd_pkg::lane_ctrl_t                  ctrl_i,
  input  logic [tpqd_pkg::POS_W-1:0]            pos_i,
  input  logic [tpqd_pkg::TIME_W-1:0]           d1_i,
  input  logic [tpqd_pkg::TIME_W-1:0]           d2_i,
  input  logic signed [tpqd_pkg::SQ_W-1:0]      d1sq_i,
  input  logic signed [tpqd_pkg::SQ_W-1:0]      d2sq_i,
  input  logic [tpqd_pkg::DEN_W-2:0]            den_i,
  output logic                                  busy_o,
  output logic [tpqd_pkg::POS_W-1:0]            vel_o,
  output logic [tpqd_pkg::POS_W-1:0]            acc_o
);
  import tpqd_pkg::*;

  localparam int P_W  = DA_W + DP_W;
  localparam int M_W  = SQ_W + DP_W;
  localparam int VA_W = M_W + 1;
  localparam int AA_W = P_W + 1;
  localparam int VN_W = VA_W + VEL_SCALE_W;
  localparam int AN_W = AA_W + ACC_SCALE_W;

  logic [POS_W-1:0]       older_q, middle_q;
  logic signed [DP_W-1:0] dp1_q, dp2_q;

  logic signed [P_W-1:0]  p1, p2;
  logic signed [M_W-1:0]  m1, m2;
  logic signed [VN_W-1:0] vn;
  logic signed [AN_W-1:0] an;
  logic signed [VA_W-1:0] va;
  logic signed [AA_W-1:0] aa;
  logic [5:0]             busy;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.win_we) begin
      dp1_q <= DP_W'($signed(older_q)) - DP_W'($signed(middle_q));
      dp2_q <= DP_W'($signed(pos_i)) - DP_W'($signed(middle_q));
      if (ctrl_i.win_shift) begin
        older_q <= middle_q;
      end
      middle_q <= pos_i;
    end
  end

  tpqd_smul #(.WA(DA_W), .NB(DP_W), .B_SIGNED(1'b1)) u_p1 (
    .clk_i, .rst_ni, .start_i(ctrl_i.p1_go), .a_i($signed({1'b0, d1_i})),
    .b_i(dp2_q), .busy_o(busy[0]), .p_o(p1)
  );

  tpqd_smul #(.WA(DA_W), .NB(DP_W), .B_SIGNED(1'b1)) u_p2 (
    .clk_i, .rst_ni, .start_i(ctrl_i.p1_go), .a_i($signed({1'b0, d2_i})),
    .b_i(dp1_q), .busy_o(busy[1]), .p_o(p2)
  );

  tpqd_smul #(.WA(SQ_W), .NB(DP_W), .B_SIGNED(1'b1)) u_m1 (
    .clk_i, .rst_ni, .start_i(ctrl_i.p2_go), .a_i(d1sq_i),
    .b_i(dp2_q), .busy_o(busy[2]), .p_o(m1)
  );

  tpqd_smul #(.WA(SQ_W), .NB(DP_W), .B_SIGNED(1'b1)) u_m2 (
    .clk_i, .rst_ni, .start_i(ctrl_i.p2_go), .a_i(d2sq_i),
    .b_i(dp1_q), .busy_o(busy[3]), .p_o(m2)
  );

  assign aa = AA_W'(p1) + AA_W'(p2);
  assign va = VA_W'(m1) - VA_W'(m2);

  tpqd_smul #(.WA(AA_W), .NB(ACC_SCALE_W), .B_SIGNED(1'b0)) u_an (
    .clk_i, .rst_ni, .start_i(ctrl_i.p2_go), .a_i(aa),
    .b_i(ACC_SCALE), .busy_o(busy[4]), .p_o(an)
  );

  tpqd_smul #(.WA(VA_W), .NB(VEL_SCALE_W), .B_SIGNED(1'b0)) u_vn (
    .clk_i, .rst_ni, .start_i(ctrl_i.p3_go), .a_i(va),
    .b_i(VEL_SCALE), .busy_o(busy[5]), .p_o(vn)
  );

  logic div_busy_v, div_busy_a;

  tpqd_rdiv #(.WN(VN_W), .WD(DEN_W - 1)) u_div_v (
    .clk_i, .rst_ni, .start_i(ctrl_i.div_go), .num_i(vn), .den_i(den_i),
    .busy_o(div_busy_v), .quo_o(vel_o)
  );

  tpqd_rdiv #(.WN(AN_W), .WD(DEN_W - 1)) u_div_a (
    .clk_i, .rst_ni, .start_i(ctrl_i.div_go), .num_i(an), .den_i(den_i),
    .busy_o(div_busy_a), .quo_o(acc_o)
  );

  assign busy_o = (|busy) | div_busy_v | div_busy_a;

endmodule
`default_nettype wire

// File: sv/tpqd_chk.sv
`default_nettype none
module tpqd_chk (
  input wire logic                           clk_i,
  input wire logic                           rst_ni,
  input wire logic                           s_axis_tvalid,
  input wire logic                           s_axis_tready,
  input wire logic                           m_axis_tvalid,
  input wire logic                           m_axis_tready,
  input wire logic [tpqd_pkg::M_TDATA_W-1:0] m_axis_tdata
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("output word dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("output word changed while stalled");

  a_no_instant: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> !$past(s_axis_tvalid && s_axis_tready))
    else $error("result appeared directly after an input word");

  a_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$isunknown({m_axis_tvalid, s_axis_tready}))
    else $error("handshake output is unknown");

endmodule

bind three_point_quadratic_derivatives tpqd_chk u_chk (.*);
`default_nettype wire

// File: tb/three_point_quadratic_derivatives_test.sv
`timescale 1ns / 1ps
module three_point_quadratic_derivatives_test;
  import tpqd_pkg::*;

  localparam int LIMIT_CYCLES = 4000000;
  localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

  typedef struct packed {
    logic [MAX_AXES-1:0][POS_W-1:0] pos;
    logic [TIME_W-1:0]              t;
  } point_t;

  typedef struct packed {
    logic [MAX_AXES-1:0][POS_W-1:0] acc;
    logic [MAX_AXES-1:0][POS_W-1:0] vel;
    logic [TIME_W-1:0]              t;
  } deriv_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [STEP_W-1:0]    cfg_wdata_i;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata;
  logic                 s_axis_tlast;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_axis_tdata;

  three_point_quadratic_derivatives dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tlast,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  // Predictor state of the point window.
  logic [STEP_W-1:0]              step_ns;
  logic [TIME_W-1:0]              older_t, middle_t;
  logic [MAX_AXES-1:0][POS_W-1:0] older_p, middle_p;
  int                             fill;

  deriv_t  deriv_q[$];
  int      errors = 0;
  int      cycles = 0;
  int      hold_cycles = 0;
  bit      hold_req = 1'b0;
  bit      hold_seen = 1'b0;
  bit      steady;
  logic [TIME_W-1:0]              traj_t;
  logic [MAX_AXES-1:0][POS_W-1:0] traj_p;

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // Rounded quotient of a signed numerator by a positive span, saturated to 32 bits.
  function automatic logic [31:0] round_sat(input logic signed [255:0] num,
                                            input logic [255:0] den);
    logic [255:0] mag, q;
    logic         neg;
    neg = num < 0;
    mag = neg ? -num : num;
    q = (2 * mag + den) / (2 * den);
    if (neg) begin
      if (q > 256'h8000_0000) q = 256'h8000_0000;
      return -q[31:0];
    end
    if (q > 256'h7fff_ffff) q = 256'h7fff_ffff;
    return q[31:0];
  endfunction

  task automatic predict_point(input point_t p, input logic last);
    logic [TIME_W:0]        lim;
    logic [TIME_W-1:0]      tc;
    logic signed [255:0]    d1, d2, dp1, dp2, vn, an;
    logic [255:0]           den;
    deriv_t                 r;
    tc = p.t;
    if (fill != 0) begin
      lim = middle_t + step_ns;
      if (p.t > lim) lim = {1'b0, p.t};
      tc = lim > TIME_MAX ? TIME_MAX : lim[TIME_W-1:0];
    end
    if (fill >= 2) begin
      r = '0;
      r.t = middle_t;
      d1 = 256'(middle_t) - 256'(older_t);
      d2 = 256'(tc) - 256'(middle_t);
      den = d1 * d2 * (d1 + d2);
      if (den != 0) begin
        for (int i = 0; i < MAX_AXES; i++) begin
          dp1 = $signed(older_p[i]) - $signed(middle_p[i]);
          dp2 = $signed(p.pos[i]) - $signed(middle_p[i]);
          vn = (dp2 * d1 * d1 - dp1 * d2 * d2) * 1000000000;
          an = (dp2 * d1 + dp1 * d2) * 256'd2000000000000000000;
          r.vel[i] = round_sat(vn, den);
          r.acc[i] = round_sat(an, den);
        end
      end
      deriv_q = {deriv_q, r};
    end
    if (fill >= 1) begin
      older_t = middle_t;
      older_p = middle_p;
      fill = 2;
    end else begin
      fill = 1;
    end
    middle_t = tc;
    middle_p = p.pos;
    if (last) fill = 0;
  endtask

  task automatic send_point(input point_t p, input logic last);
    if (!steady && $urandom_range(99) < 13) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < 60);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= p;
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_point(p, last);
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (deriv_q.size() != 0) @(posedge clk_i);
    repeat (250) @(posedge clk_i);
  endtask

  task automatic write_step(input logic [STEP_W-1:0] v);
    wait_idle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    step_ns = v;
  endtask

  always @(posedge clk_i) begin
    if (hold_req != hold_seen) begin
      hold_seen     <= hold_req;
      hold_cycles   <= 2500;
      m_axis_tready <= 1'b0;
    end else if (hold_cycles > 0) begin
      hold_cycles   <= hold_cycles - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= steady || $urandom_range(99) >= 13;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      deriv_t got, want;
      got = m_axis_tdata;
      if (deriv_q.size() == 0) begin
        report("unexpected word", m_axis_tdata[63:0], 64'd0);
      end else begin
        want = deriv_q.pop_front();
        if (got.t !== want.t) report("center_time", got.t, want.t);
        for (int i = 0; i < MAX_AXES; i++) begin
          if (got.vel[i] !== want.vel[i]) report($sformatf("vel_axis%0d", i), got.vel[i],
                                                 want.vel[i]);
          if (got.acc[i] !== want.acc[i]) report($sformatf("acc_axis%0d", i), got.acc[i],
                                                 want.acc[i]);
        end
      end
    end
  end

  function automatic logic [31:0] pick_pos(input logic [31:0] prev);
    case ($urandom_range(9))
      0: return $urandom;
      1: return $urandom_range(1) ? 32'h7fff_ffff : 32'h8000_0000;
      2: return prev + $urandom_range(1) - $urandom_range(1);
      default: return prev + $urandom_range(65535 * 64) - 65535 * 32;
    endcase
  endfunction

  // One trajectory of n points with random gaps in time, including zero, huge and backward steps.
  task automatic send_traj(input int n);
    point_t p;
    logic [TIME_W-1:0] gap;
    if ($urandom_range(9) == 0) traj_t = TIME_W'({$urandom, $urandom});
    else traj_t = TIME_W'($urandom_range(1 << 20));
    for (int i = 0; i < MAX_AXES; i++) traj_p[i] = $urandom;
    for (int k = 0; k < n; k++) begin
      case ($urandom_range(9))
        0: gap = '0;
        1: gap = TIME_W'({$urandom, $urandom});
        2: gap = TIME_W'($urandom_range(20));
        default: gap = TIME_W'($urandom_range(200000));
      endcase
      p.t = traj_t + gap;
      if ($urandom_range(19) == 0) p.t = traj_t - TIME_W'($urandom_range(5000));
      if (p.t < traj_t && gap != 0 && $urandom_range(3) != 0) p.t = TIME_MAX;
      traj_t = p.t;
      for (int i = 0; i < MAX_AXES; i++) traj_p[i] = pick_pos(traj_p[i]);
      p.pos = traj_p;
      send_point(p, k == n - 1);
    end
  endtask

  task automatic test_directed();
    point_t p;
    p.t = 0;        p.pos = '0;                 send_point(p, 1'b0);
    p.t = 100;      p.pos = {4{32'h7fff_ffff}}; send_point(p, 1'b0);
    p.t = 200;      p.pos = {4{32'h8000_0000}}; send_point(p, 1'b0);
    p.t = 30000;    p.pos = {32'h0001_0000, 32'hffff_0000, 32'h0, 32'h7fff_ffff};
    send_point(p, 1'b0);
    p.t = 30001;    p.pos = {4{32'h8000_0000}}; send_point(p, 1'b1);
    p.t = TIME_MAX - 5; p.pos = {4{32'h1234_5678}}; send_point(p, 1'b0);
    p.t = 0;        p.pos = {4{32'hedcb_a988}}; send_point(p, 1'b0);
    p.t = TIME_MAX; p.pos = '0;                 send_point(p, 1'b0);
    p.t = 5;        p.pos = {4{32'h7fff_ffff}}; send_point(p, 1'b1);
    p.t = 1000;     p.pos = '1;                 send_point(p, 1'b1);
    p.t = 1000;     p.pos = '0;                 send_point(p, 1'b0);
    p.t = 1000;     p.pos = '1;                 send_point(p, 1'b1);
    for (int k = 0; k < 6; k++) begin
      p.t = TIME_W'(20000 * k + 7);
      p.pos = {32'(k * k * 65536), 32'(-k * 65536), 32'(k), 32'h4000_0000 - k};
      send_point(p, k == 5);
    end
  endtask

  task automatic test_config_sweep();
    point_t p;
    logic [STEP_W-1:0] steps[5];
    steps = '{30'd1, 30'd1000000000, 30'd0, 30'h3fff_ffff, 30'd10000};
    foreach (steps[s]) begin
      write_step(steps[s]);
      for (int k = 0; k < 4; k++) begin
        p.t = (k == 3) ? TIME_MAX - 2 : TIME_W'(k * 3);
        p.pos = {$urandom, $urandom, $urandom, $urandom};
        send_point(p, k == 3);
      end
      send_traj(6);
    end
  endtask

  task automatic test_backpressure();
    wait_idle();
    hold_req = ~hold_req;
    send_traj(12);
    wait_idle();
  endtask

  task automatic test_random(input int items);
    int sent, n;
    sent = 0;
    while (sent < items) begin
      if ($urandom_range(29) == 0) write_step($urandom_range(1) ?
                                              STEP_W'($urandom_range(200000)) :
                                              STEP_W'($urandom));
      steady = sent < 400;
      n = $urandom_range(7) == 0 ? $urandom_range(2) + 1 : $urandom_range(40, 3);
      send_traj(n);
      sent += n;
    end
    steady = 0;
  endtask

  initial begin
    clk_i = 0;
    rst_ni = 0;
    cfg_we_i = 0;
    cfg_wdata_i = '0;
    s_axis_tvalid = 0;
    s_axis_tdata = '0;
    s_axis_tlast = 0;
    steady = 0;
    step_ns = STEP_RESET;
    older_t = '0;
    middle_t = '0;
    older_p = '0;
    middle_p = '0;
    fill = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_config_sweep();
    test_backpressure();
    test_random(1850);
    wait_idle();
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
